FILE: design/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg: shared definitions for the sorted sequence merger
// Request codes, channel field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package ssm_pkg;

    // Widths of the channel fields.
    localparam int ACTION_W = 2;
    localparam int KEY_W    = 32;

    // Request codes carried in the action field.
    localparam logic [ACTION_W-1:0] ACT_FIRST  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SECOND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MERGE  = 2'd2;

    // Merge sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PICK,
        ST_SEND
    } t_state;

endpackage

FILE: design/ssm_if.sv
// ----------------------------------------------------------------------------
// ssm_if: request and result channels of the sorted sequence merger
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------

// Input channel: append or merge requests.
interface ssm_in_if;
    logic                             valid;
    logic                             ready;
    logic [ssm_pkg::ACTION_W-1:0]     action;
    logic signed [ssm_pkg::KEY_W-1:0] key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

// Output channel: merged keys.
interface ssm_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [ssm_pkg::KEY_W-1:0] key_out;
    logic                             last;
    logic                             empty_res;
    logic                             dropped;

    modport source (output valid, output key_out, output last, output empty_res,
                    output dropped, input ready);
    modport sink   (input valid, input key_out, input last, input empty_res,
                    input dropped, output ready);
endinterface

FILE: design/sorted_sequence_merger.sv
// ----------------------------------------------------------------------------
// sorted_sequence_merger: two-way merge of two ascending key lists
// Stores keys of two sorted sequences and emits them merged in ascending order.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Fields                               | Request moves when
//  --------+-----------+--------------------------------------+---------------------
//  i_in    | in        | action, key                          | valid && ready
//  o_out   | out       | key_out, last, empty_res, dropped    | valid && ready
//
// An append leaves the sequencer idle, so ready stays high.
// A merge leaves idle, then for each emitted key runs a store read, a compare
// and a send, waiting in the send step while the output is stalled; the registered
// read port of each store and the single shared comparator set these steps.
// An empty merge presents its one result in the cycle right after the request.
// Reset clears the fill counts, the overflow flag and the sequencer; the
// stores are not cleared, only entries below the fill count are ever used.
// Input ready is low for the whole merge; a stalled result holds its register.
module sorted_sequence_merger #(
    parameter int DEPTH    = 32,
    parameter int KEY_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ssm_in_if.sink        i_in,
    ssm_out_if.source     o_out
);
    import ssm_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    // Sequencer and fill state.
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0]    r_cnt_b, n_cnt_b;
    logic [CNT_W-1:0]    r_i, n_i;
    logic [CNT_W-1:0]    r_j, n_j;
    logic                r_ovf, n_ovf;
    logic                r_out_valid, n_out_valid;

    // Result payload.
    logic signed [KEY_W-1:0] r_key_out, n_key_out;
    logic                    r_last, n_last;
    logic                    r_empty, n_empty;
    logic                    r_drop, n_drop;

    // Key stores and their registered read data.
    logic signed [KEY_BITS-1:0] r_mem_a [DEPTH];
    logic signed [KEY_BITS-1:0] r_mem_b [DEPTH];
    logic signed [KEY_BITS-1:0] r_rd_a;
    logic signed [KEY_BITS-1:0] r_rd_b;

    logic                       w_acc;
    logic                       w_wr_a;
    logic                       w_wr_b;
    logic signed [KEY_BITS-1:0] w_key_st;
    logic                       w_a_le_b;
    logic                       w_take_a;

    // Handshake and the incoming key at store width.
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_key_st   = KEY_BITS'(i_in.key);
    assign w_wr_a     = w_acc && (i_in.action == ACT_FIRST)  && (r_cnt_a != FULL);
    assign w_wr_b     = w_acc && (i_in.action == ACT_SECOND) && (r_cnt_b != FULL);

    // First store: write at the fill level, read at the merge cursor.
    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            r_mem_a[r_cnt_a[IDX_W-1:0]] <= w_key_st;
        end
        if (r_state == ST_READ) begin
            r_rd_a <= r_mem_a[r_i[IDX_W-1:0]];
        end
    end

    // Second store: same arrangement.
    always_ff @(posedge i_clk) begin
        if (w_wr_b) begin
            r_mem_b[r_cnt_b[IDX_W-1:0]] <= w_key_st;
        end
        if (r_state == ST_READ) begin
            r_rd_b <= r_mem_b[r_j[IDX_W-1:0]];
        end
    end

    // Shared comparator; ties go to the first sequence.
    assign w_a_le_b = (r_rd_a <= r_rd_b);
    assign w_take_a = (r_i < r_cnt_a) && ((r_j >= r_cnt_b) || w_a_le_b);

    // Next state and next values of the sequencer.
    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_i         = r_i;
        n_j         = r_j;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_key_out   = r_key_out;
        n_last      = r_last;
        n_empty     = r_empty;
        n_drop      = r_drop;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (i_in.action)
                        ACT_FIRST: begin
                            if (r_cnt_a == FULL) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_cnt_a = r_cnt_a + CNT_W'(1);
                            end
                        end
                        ACT_SECOND: begin
                            if (r_cnt_b == FULL) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_cnt_b = r_cnt_b + CNT_W'(1);
                            end
                        end
                        ACT_MERGE: begin
                            n_i    = '0;
                            n_j    = '0;
                            n_drop = r_ovf;
                            n_ovf  = 1'b0;
                            if ((r_cnt_a == '0) && (r_cnt_b == '0)) begin
                                n_key_out   = '0;
                                n_last      = 1'b1;
                                n_empty     = 1'b1;
                                n_out_valid = 1'b1;
                                n_state     = ST_SEND;
                            end else begin
                                n_empty = 1'b0;
                                n_state = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_PICK;
            end
            ST_PICK: begin
                if (w_take_a) begin
                    n_key_out = KEY_W'(r_rd_a);
                    n_i       = r_i + CNT_W'(1);
                end else begin
                    n_key_out = KEY_W'(r_rd_b);
                    n_j       = r_j + CNT_W'(1);
                end
                n_last      = (n_i == r_cnt_a) && (n_j == r_cnt_b);
                n_out_valid = 1'b1;
                n_state     = ST_SEND;
            end
            ST_SEND: begin
                if (o_out.ready) begin
                    n_out_valid = 1'b0;
                    if (r_last) begin
                        n_cnt_a = '0;
                        n_cnt_b = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_i         <= n_i;
            r_j         <= n_j;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_key_out <= n_key_out;
        r_last    <= n_last;
        r_empty   <= n_empty;
        r_drop    <= n_drop;
    end

    // Output channel.
    assign o_out.valid     = r_out_valid;
    assign o_out.key_out   = r_key_out;
    assign o_out.last      = r_last;
    assign o_out.empty_res = r_empty;
    assign o_out.dropped   = r_drop;

endmodule

FILE: design/ssm_checker.sv
// ----------------------------------------------------------------------------
// ssm_checker: port-level checks for the sorted sequence merger
// Watches both channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
module ssm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic [ssm_pkg::ACTION_W-1:0]     i_in_action,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic signed [ssm_pkg::KEY_W-1:0] i_out_key,
    input logic                             i_out_last,
    input logic                             i_out_empty
);
    import ssm_pkg::*;

    // A pending result is held until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // No request is taken while a result is pending.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready during a merge");

    // A merge request closes the input for at least the next cycle.
    a_merge_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_action == ACT_MERGE) |=> !i_in_ready)
        else $error("input ready right after a merge request");

    // An empty merge gives a single final result with a zero key.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_empty |-> i_out_last && (i_out_key == '0))
        else $error("empty result not final or key nonzero");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind sorted_sequence_merger ssm_checker u_ssm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_action (i_in.action),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_key   (o_out.key_out),
    .i_out_last  (o_out.last),
    .i_out_empty (o_out.empty_res)
);

FILE: dv/tb_sorted_sequence_merger.sv
// ----------------------------------------------------------------------------
// tb_sorted_sequence_merger: testbench of the sorted sequence merger
// Loads two key stores through append requests and checks every merged key
// against an in-bench merge of the same stores or a result from the table.
// A directed table covers empty merges, key extremes, equal keys, one store
// left over, full stores and the unused request code. Random batches of
// mostly sorted keys follow, under changing idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_sorted_sequence_merger;

    import ssm_pkg::*;

    localparam int DEPTH          = 32;
    localparam int RANDOM_ITEMS   = 180;
    localparam int DRAIN_CYCLES   = 20;
    localparam int TIMEOUT_CYCLES = 200000;

    // Request code 3 has no meaning; the block is expected to ignore it.
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    // One result of a merge, field by field.
    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        logic                    last;
        logic                    empty_res;
        logic                    dropped;
    } t_merged_key;

    // One row of directed stimulus: a request repeated reps times, the key
    // growing by step each time. Typed rows carry their single result.
    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic signed [KEY_W-1:0] key;
        int                      reps;
        int                      step;
        bit                      typed;
        t_merged_key             result;
    } t_stim_row;

    localparam t_merged_key EMPTY_MERGE = '{32'sd0, 1'b1, 1'b1, 1'b0};
    localparam t_merged_key NO_RESULT   = '0;

    localparam int STIM_ROWS = 20;
    localparam t_stim_row STIM_TABLE [STIM_ROWS] = '{
        // Merge straight after reset gives the single empty result.
        '{ACT_MERGE,  32'sd0,        1, 0, 1'b1, EMPTY_MERGE},
        // Most negative and most positive keys pass through unchanged.
        '{ACT_FIRST,  KEY_MIN,       1, 0, 1'b0, NO_RESULT},
        '{ACT_MERGE,  32'sd0,        1, 0, 1'b1, '{KEY_MIN, 1'b1, 1'b0, 1'b0}},
        '{ACT_SECOND, KEY_MAX,       1, 0, 1'b0, NO_RESULT},
        '{ACT_MERGE,  32'sd0,        1, 0, 1'b1, '{KEY_MAX, 1'b1, 1'b0, 1'b0}},
        // The unused code must leave both stores empty.
        '{ACT_NONE,   -32'sd1,       1, 0, 1'b0, NO_RESULT},
        '{ACT_MERGE,  32'sd0,        1, 0, 1'b1, EMPTY_MERGE},
        // Equal keys across and within the stores.
        '{ACT_FIRST,  -32'sd5,       1, 0, 1'b0, NO_RESULT},
        '{ACT_FIRST,  32'sd3,        2, 0, 1'b0, NO_RESULT},
        '{ACT_SECOND, 32'sd3,        1, 0, 1'b0, NO_RESULT},
        '{ACT_SECOND, 32'sd10,       1, 0, 1'b0, NO_RESULT},
        '{ACT_MERGE,  32'sd0,        1, 0, 1'b0, NO_RESULT},
        // Only the second store holds keys.
        '{ACT_SECOND, 32'shAAAA_AAAA, 4, 32'h1111_1111, 1'b0, NO_RESULT},
        '{ACT_MERGE,  32'sd0,        1, 0, 1'b0, NO_RESULT},
        // Both stores full, one append to the first dropped.
        '{ACT_FIRST,  -32'sd100,     33, 3, 1'b0, NO_RESULT},
        '{ACT_SECOND, -32'sd99,      32, 3, 1'b0, NO_RESULT},
        '{ACT_MERGE,  32'sd0,        1, 0, 1'b0, NO_RESULT},
        // The drop flag must be cleared by the merge before.
        '{ACT_MERGE,  32'sd0,        1, 0, 1'b1, EMPTY_MERGE},
        // Second store overflows by two.
        '{ACT_SECOND, 32'sd1,        34, 1, 1'b0, NO_RESULT},
        '{ACT_MERGE,  32'sd0,        1, 0, 1'b0, NO_RESULT}
    };

    logic i_clk;
    logic i_rst_n;

    ssm_in_if  req_if ();
    ssm_out_if res_if ();

    sorted_sequence_merger #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // Bench copy of the two stores and the drop flag.
    logic signed [KEY_W-1:0] first_list [$];
    logic signed [KEY_W-1:0] second_list [$];
    bit                      drop_pending;

    // Merged keys still owed by the block, oldest first.
    t_merged_key owed_keys [$];

    int error_count;
    int items_sent;
    int sender_idle_pct;
    int receiver_idle_pct;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Updates the bench stores for one accepted request. A merge computes the
    // merged sequence; with keep set its keys are added to the owed list.
    function automatic void apply_request(logic [ACTION_W-1:0] action,
                                          logic signed [KEY_W-1:0] key, bit keep);
        t_merged_key res;
        int          i;
        int          j;
        int          total;
        i = 0;
        j = 0;
        case (action)
            ACT_FIRST: begin
                if (first_list.size() >= DEPTH) drop_pending = 1'b1;
                else first_list.push_back(key);
            end
            ACT_SECOND: begin
                if (second_list.size() >= DEPTH) drop_pending = 1'b1;
                else second_list.push_back(key);
            end
            ACT_MERGE: begin
                total = first_list.size() + second_list.size();
                if (total == 0) begin
                    res = '{32'sd0, 1'b1, 1'b1, drop_pending};
                    if (keep) owed_keys.push_back(res);
                end
                // Ties go to the first store; the leftover store drains last.
                for (int n = 0; n < total; n++) begin
                    if (i < first_list.size() &&
                        (j >= second_list.size() || first_list[i] <= second_list[j])) begin
                        res.key_out = first_list[i];
                        i++;
                    end else begin
                        res.key_out = second_list[j];
                        j++;
                    end
                    res.last      = (n + 1 == total);
                    res.empty_res = 1'b0;
                    res.dropped   = drop_pending;
                    if (keep) owed_keys.push_back(res);
                end
                first_list.delete();
                second_list.delete();
                drop_pending = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // Drives one request and waits until the block takes it. Valid stays high
    // afterwards, so back-to-back requests leave it high between them.
    task automatic send_request(logic [ACTION_W-1:0] action, logic signed [KEY_W-1:0] key,
                                bit typed = 1'b0, t_merged_key typed_result = '0);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.action <= action;
        req_if.key    <= key;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        apply_request(action, key, !typed);
        if (typed) owed_keys.push_back(typed_result);
        if (action != ACT_NONE) items_sent++;
    endtask

    // Draws the keys of one store: mostly sorted, now and then out of order.
    // Small values make equal keys common; a few lists overflow the store.
    function automatic void draw_keys(ref int keys [$]);
        int len;
        len = ($urandom_range(0, 99) < 5) ? $urandom_range(30, 36) : $urandom_range(0, 6);
        repeat (len) begin
            case ($urandom_range(0, 3))
                0, 1:    keys.push_back(int'($urandom));
                2:       keys.push_back(int'($urandom_range(0, 6)) - 3);
                default: keys.push_back($urandom_range(0, 1) ? int'(KEY_MAX) : int'(KEY_MIN));
            endcase
        end
        if ($urandom_range(0, 9) != 0) keys.sort();
    endfunction

    // One random batch: both stores loaded in random interleave with occasional unused requests, then a merge.
    task automatic send_merge_batch();
        int first_keys [$];
        int second_keys [$];
        bit to_first;
        draw_keys(first_keys);
        draw_keys(second_keys);
        while (first_keys.size() + second_keys.size() > 0) begin
            if ($urandom_range(0, 19) == 0) send_request(ACT_NONE, $urandom);
            to_first = (second_keys.size() == 0) ||
                       (first_keys.size() != 0 && $urandom_range(0, 1) == 1);
            if (to_first) send_request(ACT_FIRST, first_keys.pop_front());
            else send_request(ACT_SECOND, second_keys.pop_front());
        end
        send_request(ACT_MERGE, $urandom);
    endtask

    // Result checker and receiver stall.
    always @(posedge i_clk) begin : result_check
        t_merged_key want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (owed_keys.size() == 0) begin
                    $error("unexpected result: key_out %0d, last %0b",
                           res_if.key_out, res_if.last);
                    error_count++;
                end else begin
                    want = owed_keys.pop_front();
                    if (res_if.key_out !== want.key_out) begin
                        $error("key_out mismatch: expected %0d, actual %0d",
                               want.key_out, res_if.key_out);
                        error_count++;
                    end
                    if (res_if.last !== want.last) begin
                        $error("last mismatch: expected %0b, actual %0b",
                               want.last, res_if.last);
                        error_count++;
                    end
                    if (res_if.empty_res !== want.empty_res) begin
                        $error("empty_res mismatch: expected %0b, actual %0b",
                               want.empty_res, res_if.empty_res);
                        error_count++;
                    end
                    if (res_if.dropped !== want.dropped) begin
                        $error("dropped mismatch: expected %0b, actual %0b",
                               want.dropped, res_if.dropped);
                        error_count++;
                    end
                end
            end
            res_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Stimulus, drain and verdict.
    initial begin
        t_stim_row row;
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.action     <= ACT_FIRST;
        req_if.key        <= '0;
        error_count       = 0;
        items_sent        = 0;
        drop_pending      = 1'b0;
        sender_idle_pct   = 8;
        receiver_idle_pct = 67;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        for (int r = 0; r < STIM_ROWS; r++) begin
            row = STIM_TABLE[r];
            for (int n = 0; n < row.reps; n++) begin
                send_request(row.action, row.key + KEY_W'(n * row.step), row.typed,
                             row.result);
            end
        end

        // Random batches; the idle pattern changes with the request count.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent < RANDOM_ITEMS / 3) begin
                sender_idle_pct   = 8;
                receiver_idle_pct = 67;
            end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
                sender_idle_pct   = 67;
                receiver_idle_pct = 8;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            send_merge_batch();
        end
        req_if.valid <= 1'b0;

        while (owed_keys.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hang guard.
    initial begin
        #(20 * TIMEOUT_CYCLES);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
design/ssm_pkg.sv
design/ssm_if.sv
design/sorted_sequence_merger.sv
design/ssm_checker.sv
dv/tb_sorted_sequence_merger.sv
